// ===== rtl/core/fcce_pkg.sv =====
`timescale 1ns / 1ps

package fcce_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 65536;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned ENTRY_W     = 32;

  // End-of-chain threshold and sector size
  localparam logic [ENTRY_W-1:0] END_MARK = 32'h0fff_fff8;
  localparam int unsigned SECTOR_SHIFT = 9;
  localparam int unsigned OFFSET_W     = 32;
  localparam int unsigned REM_W        = OFFSET_W - SECTOR_SHIFT;

  // Configuration
  localparam int unsigned SPC_W     = 8;
  localparam logic [SPC_W-1:0] SPC_RESET = 8'd8;

  // Operation codes
  localparam int unsigned KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WALK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FREE   = 3'd4;

  // Status codes
  localparam int unsigned STAT_W = 2;
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;

endpackage

// ===== rtl/core/fcce_ram.sv =====
`timescale 1ns / 1ps

module fcce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fat_cluster_chain_engine.sv =====
`timescale 1ns / 1ps
// Write, unused kinds and chain operations stopped before any read go from ST_ISSUE to
// ST_FIN and the output register; read, walk, append and free step through the table
// links in between, one memory read per cycle with the same-cycle write forwarded.
// One transaction is handled at a time; the next is taken once the last is in the
// output register. Reset (rst_n low, synchronous) starts a clearing pass that zeroes
// all 65536 table entries; no input is taken until it ends. sectors_per_cluster resets to 8.
module fat_cluster_chain_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // cluster[31:0], value[63:32], byte_offset[95:64]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value[31:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  localparam int unsigned IW = fcce_pkg::IDX_W;
  localparam int unsigned EW = fcce_pkg::ENTRY_W;
  localparam int unsigned RW = fcce_pkg::REM_W;
  localparam int unsigned CW = fcce_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_STEP,
    ST_FIN
  } state_t;

  state_t                       state_r, state_nxt;
  logic [fcce_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [EW-1:0]                cur_r, cur_nxt;
  logic [EW-1:0]                val_r, val_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [CW-1:0]                reads_r, reads_nxt;
  logic [EW-1:0]                res_r, res_nxt;
  logic [fcce_pkg::STAT_W-1:0]  st_r, st_nxt;
  logic                         fwd_r, fwd_nxt;
  logic [EW-1:0]                fwd_data_r, fwd_data_nxt;
  logic [IW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [fcce_pkg::SPC_W-1:0]   spc_r, spc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [EW-1:0]                out_data_r, out_data_nxt;
  logic [fcce_pkg::STAT_W-1:0]  out_stat_r, out_stat_nxt;

  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  logic [EW-1:0]                ram_wdata;
  logic [IW-1:0]                ram_raddr;
  logic [EW-1:0]                ram_rdata;

  logic [fcce_pkg::SPC_W-1:0]   spc_eff;
  logic [RW-1:0]                spc_ext;
  logic [RW-1:0]                rem_dec;
  logic [EW-1:0]                entry;
  logic                         end_hit;
  logic                         go_issue;
  logic [EW-1:0]                cand_cur;
  logic                         fin;
  logic [EW-1:0]                fin_res;
  logic [fcce_pkg::STAT_W-1:0]  fin_st;
  logic                         issued;

  fcce_ram #(
    .WIDTH(EW),
    .DEPTH(fcce_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Cluster size of zero counts as one
  assign spc_eff = (spc_r == '0) ? fcce_pkg::SPC_W'(1) : spc_r;
  assign spc_ext = RW'(spc_eff);
  assign rem_dec = rem_r - spc_ext;

  // Entry just read, with the same-cycle write forwarded
  assign entry   = fwd_r ? fwd_data_r : ram_rdata;
  assign end_hit = (entry >= fcce_pkg::END_MARK);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  // Sequencer: decide, read, modify and write back one link a cycle
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cur_nxt       = cur_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    reads_nxt     = reads_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    clr_cnt_nxt   = clr_cnt_r;
    spc_nxt       = cfg_wr_en ? cfg_wr_data : spc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r[IW-1:0];
    ram_wdata     = '0;
    ram_raddr     = cur_r[IW-1:0];
    go_issue      = 1'b0;
    cand_cur      = cur_r;
    fin           = 1'b0;
    fin_res       = '0;
    fin_st        = fcce_pkg::STAT_OK;
    issued        = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          cur_nxt   = in_tdata[31:0];
          val_nxt   = in_tdata[63:32];
          rem_nxt   = in_tdata[95:64+fcce_pkg::SECTOR_SHIFT];
          reads_nxt = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (kind_r)
          fcce_pkg::KIND_READ,
          fcce_pkg::KIND_APPEND,
          fcce_pkg::KIND_FREE: begin
            go_issue = 1'b1;
          end
          fcce_pkg::KIND_WRITE: begin
            fin = 1'b1;
            if (cur_r[EW-1:IW] != '0) begin
              fin_st = fcce_pkg::STAT_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = val_r;
            end
          end
          fcce_pkg::KIND_WALK: begin
            if (rem_r < spc_ext) begin
              fin     = 1'b1;
              fin_res = cur_r;
            end else begin
              go_issue = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_STEP: begin
        cand_cur = entry;
        case (kind_r)
          fcce_pkg::KIND_READ: begin
            fin     = 1'b1;
            fin_res = entry;
          end
          fcce_pkg::KIND_WALK: begin
            rem_nxt = rem_dec;
            if (end_hit) begin
              fin = 1'b1;
            end else if (rem_dec < spc_ext) begin
              fin     = 1'b1;
              fin_res = entry;
            end else begin
              go_issue = 1'b1;
            end
          end
          fcce_pkg::KIND_APPEND: begin
            if (end_hit) begin
              ram_we    = 1'b1;
              ram_wdata = val_r;
              fin       = 1'b1;
            end else begin
              go_issue = 1'b1;
            end
          end
          fcce_pkg::KIND_FREE: begin
            ram_we = 1'b1;
            if (end_hit) begin
              fin = 1'b1;
            end else begin
              go_issue = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_stat_nxt  = st_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Check step limit and range, then read the next link
    if (go_issue) begin
      if (reads_r == CW'(fcce_pkg::TABLE_DEPTH)) begin
        fin    = 1'b1;
        fin_st = fcce_pkg::STAT_LIMIT;
      end else if (cand_cur[EW-1:IW] != '0) begin
        fin    = 1'b1;
        fin_st = fcce_pkg::STAT_RANGE;
      end else begin
        issued    = 1'b1;
        ram_raddr = cand_cur[IW-1:0];
        cur_nxt   = cand_cur;
        reads_nxt = reads_r + CW'(1);
        state_nxt = ST_STEP;
      end
    end

    // Hold the outcome until the output register is free
    if (fin) begin
      state_nxt = ST_FIN;
      st_nxt    = fin_st;
      res_nxt   = (fin_st == fcce_pkg::STAT_OK) ? fin_res : '0;
    end
  end

  // Forward a write that collides with the read issued in the same cycle
  assign fwd_nxt      = issued && ram_we && (ram_waddr == ram_raddr);
  assign fwd_data_nxt = ram_wdata;

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      spc_r       <= fcce_pkg::SPC_RESET;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      spc_r       <= spc_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= fwd_nxt;
    end
    kind_r     <= kind_nxt;
    cur_r      <= cur_nxt;
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    reads_r    <= reads_nxt;
    res_r      <= res_nxt;
    st_r       <= st_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

`ifndef ASSERT_OFF
  // A walk never writes the table
  a_walk_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && kind_r == fcce_pkg::KIND_WALK) |-> !ram_we)
    else $error("table written during walk");

  // Forwarded data only follows a write in the previous cycle
  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(ram_we))
    else $error("forward without preceding write");

  // Read count never passes the table depth
  a_reads_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (reads_r <= CW'(fcce_pkg::TABLE_DEPTH)))
    else $error("step counter past depth");

  // A failed operation reports a zero result
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != fcce_pkg::STAT_OK) |-> (out_data_r == '0))
    else $error("non-zero result with error status");
`endif

endmodule

// ===== tb/fat_cluster_chain_engine_tb.sv =====
`timescale 1ns / 1ps

module fat_cluster_chain_engine_tb;
  import fcce_pkg::*;

  localparam int unsigned RUN_LIMIT = 2_000_000;
  // Longest chain the random traffic may send; heavier ones become reads
  localparam int unsigned COST_CAP  = 48;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ENTRY_W-1:0] cluster;
    logic [ENTRY_W-1:0] value;
    logic [OFFSET_W-1:0] offset;
  } fat_req_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] value;
    logic [STAT_W-1:0]  status;
  } fat_resp_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] idx;
    logic [ENTRY_W-1:0] old;
  } fat_undo_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata    = '0;
  logic [2:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // Shadow of the allocation table and the cluster size register
  logic [ENTRY_W-1:0] fat_tbl [TABLE_DEPTH];
  logic [SPC_W-1:0]   spc_reg;
  fat_undo_t          table_undo[$];

  fat_resp_t   pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_left      = 0;
  bit          steady_flow    = 1'b0;

  fat_cluster_chain_engine u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  function automatic fat_req_t make_req(input logic [KIND_W-1:0] kind,
                                        input logic [31:0] cluster,
                                        input logic [31:0] value,
                                        input logic [31:0] offset);
    fat_req_t r;
    r.kind    = kind;
    r.cluster = cluster;
    r.value   = value;
    r.offset  = offset;
    return r;
  endfunction

  // Write one table entry, keeping the old value when only costing an operation
  function automatic void tbl_store(input logic [31:0] idx, input logic [31:0] val,
                                    input bit dry);
    if (dry)
      table_undo.push_back({idx, fat_tbl[idx[IDX_W-1:0]]});
    fat_tbl[idx[IDX_W-1:0]] = val;
  endfunction

  // Carry out one transaction on the shadow table; count the links read.
  // Stop early once more than cap reads would be needed.
  function automatic void fat_execute(input fat_req_t r, input bit dry,
                                      input int unsigned cap, output fat_resp_t rsp,
                                      output int unsigned reads);
    logic [31:0] cur;
    logic [31:0] nxt;
    logic [31:0] links;
    logic [31:0] spc;
    rsp.value  = '0;
    rsp.status = STAT_OK;
    reads      = 0;
    cur        = r.cluster;
    case (r.kind)
      KIND_READ: begin
        if (r.cluster < TABLE_DEPTH)
          rsp.value = fat_tbl[r.cluster[IDX_W-1:0]];
        else
          rsp.status = STAT_RANGE;
      end
      KIND_WRITE: begin
        if (r.cluster < TABLE_DEPTH)
          tbl_store(r.cluster, r.value, dry);
        else
          rsp.status = STAT_RANGE;
      end
      KIND_WALK: begin
        spc   = (spc_reg == '0) ? 32'd1 : 32'(spc_reg);
        links = (r.offset >> SECTOR_SHIFT) / spc;
        while (links != 0) begin
          if (reads >= TABLE_DEPTH) begin
            rsp.status = STAT_LIMIT;
            break;
          end
          if (cur >= TABLE_DEPTH) begin
            rsp.status = STAT_RANGE;
            break;
          end
          if (reads >= cap) begin
            reads = cap + 1;
            break;
          end
          cur = fat_tbl[cur[IDX_W-1:0]];
          reads++;
          if (cur >= END_MARK)
            break;
          links--;
        end
        // a zero-link walk returns the start unchecked
        if (links == 0)
          rsp.value = cur;
      end
      KIND_APPEND: begin
        while (1) begin
          if (reads >= TABLE_DEPTH) begin
            rsp.status = STAT_LIMIT;
            break;
          end
          if (cur >= TABLE_DEPTH) begin
            rsp.status = STAT_RANGE;
            break;
          end
          if (reads >= cap) begin
            reads = cap + 1;
            break;
          end
          nxt = fat_tbl[cur[IDX_W-1:0]];
          reads++;
          if (nxt >= END_MARK) begin
            tbl_store(cur, r.value, dry);
            break;
          end
          cur = nxt;
        end
      end
      KIND_FREE: begin
        do begin
          if (reads >= TABLE_DEPTH) begin
            rsp.status = STAT_LIMIT;
            break;
          end
          if (cur >= TABLE_DEPTH) begin
            rsp.status = STAT_RANGE;
            break;
          end
          if (reads >= cap) begin
            reads = cap + 1;
            break;
          end
          nxt = fat_tbl[cur[IDX_W-1:0]];
          reads++;
          tbl_store(cur, '0, dry);
          cur = nxt;
        end while (cur < END_MARK);
      end
      default: ;
    endcase
  endfunction

  // Links a chain operation would read, with the table left untouched
  function automatic int unsigned chain_cost(input fat_req_t r);
    fat_resp_t   rsp;
    int unsigned n;
    fat_undo_t   u;
    fat_execute(r, 1'b1, COST_CAP, rsp, n);
    while (table_undo.size() != 0) begin
      u = table_undo.pop_back();
      fat_tbl[u.idx[IDX_W-1:0]] = u.old;
    end
    return n;
  endfunction

  // Offer one transaction, then predict its result once it is accepted
  task automatic send_req(input fat_req_t r);
    fat_resp_t   rsp;
    int unsigned n;
    while (!steady_flow && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.offset, r.value, r.cluster};
    in_tuser  <= r.kind;
    do @(posedge clk); while (!in_tready);
    fat_execute(r, 1'b0, TABLE_DEPTH, rsp, n);
    pending_results.push_back(rsp);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_cluster_size(input logic [SPC_W-1:0] spc);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= spc;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    spc_reg      = spc;
  endtask

  // Check each result transaction and drive the receiver's ready
  always @(posedge clk) begin : result_check
    fat_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", out_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.value)
          report_mismatch("result_value", out_tdata, want.value);
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
      end
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (steady_flow) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 15);
    end
  end

  // Mostly well-formed chains followed by operations on them, the rest noise
  task automatic random_traffic(input int unsigned n);
    fat_req_t    batch[$];
    logic [31:0] members[$];
    logic [31:0] c;
    logic [31:0] off;
    fat_req_t    r;
    int unsigned len;
    int unsigned cb;
    int unsigned roll;
    int unsigned sent;
    bit          dup;
    sent = 0;
    while (sent < n) begin
      batch.delete();
      members.delete();
      if ($urandom_range(99) < 70) begin
        len = $urandom_range(1, 5);
        while (members.size() < len) begin
          c = ($urandom_range(99) < 80) ? 32'($urandom_range(1, 255))
                                        : 32'($urandom_range(TABLE_DEPTH - 1,
                                                             TABLE_DEPTH - 256));
          dup = 1'b0;
          foreach (members[i])
            if (members[i] == c)
              dup = 1'b1;
          if (!dup)
            members.push_back(c);
        end
        // link the members and terminate with an end-of-chain value
        for (int i = 0; i < len; i++) begin
          if (i + 1 < len)
            c = members[i + 1];
          else
            c = $urandom_range(1) ? END_MARK : 32'($urandom_range(32'hffff_ffff, END_MARK));
          batch.push_back(make_req(KIND_WRITE, members[i], c, $urandom));
        end
        cb = ((spc_reg == '0) ? 1 : int'(spc_reg)) << SECTOR_SHIFT;
        repeat ($urandom_range(1, 4)) begin
          c    = members[$urandom_range(0, len - 1)];
          roll = $urandom_range(99);
          if (roll < 45) begin
            if ($urandom_range(9) == 0)
              off = $urandom;
            else
              off = $urandom_range(0, len + 1) * cb + $urandom_range(0, cb - 1);
            batch.push_back(make_req(KIND_WALK, c, $urandom, off));
          end else if (roll < 65) begin
            off = $urandom_range(1) ? 32'($urandom_range(1, 255)) : $urandom;
            batch.push_back(make_req(KIND_APPEND, c, off, $urandom));
          end else if (roll < 80) begin
            batch.push_back(make_req(KIND_READ, c, $urandom, $urandom));
          end else begin
            batch.push_back(make_req(KIND_FREE, c, $urandom, $urandom));
          end
        end
      end else begin
        roll = $urandom_range(2);
        c = (roll == 0) ? $urandom :
            (roll == 1) ? 32'($urandom_range(0, TABLE_DEPTH - 1)) :
                          32'($urandom_range(0, 255));
        batch.push_back(make_req(3'($urandom_range(0, 7)), c, $urandom, $urandom));
      end
      // demote chain operations that would run too long
      foreach (batch[i]) begin
        r = batch[i];
        if ((r.kind == KIND_WALK || r.kind == KIND_APPEND || r.kind == KIND_FREE) &&
            chain_cost(r) > COST_CAP)
          r.kind = KIND_READ;
        send_req(r);
        sent++;
      end
    end
  endtask

  task automatic test_table_access();
    send_req(make_req(KIND_READ,  32'd0,             $urandom,     $urandom));
    send_req(make_req(KIND_READ,  TABLE_DEPTH - 1,   $urandom,     $urandom));
    send_req(make_req(KIND_READ,  TABLE_DEPTH,       $urandom,     $urandom));
    send_req(make_req(KIND_WRITE, 32'hffff_ffff,     32'h1234_5678, $urandom));
    send_req(make_req(KIND_WRITE, TABLE_DEPTH - 1,   32'hffff_ffff, $urandom));
    send_req(make_req(KIND_READ,  TABLE_DEPTH - 1,   $urandom,     $urandom));
  endtask

  // Chain 1 -> 2 -> 3 -> end, walked, extended and freed
  task automatic test_chain_ops();
    send_req(make_req(KIND_WRITE,  32'd1, 32'd2,    '0));
    send_req(make_req(KIND_WRITE,  32'd2, 32'd3,    '0));
    send_req(make_req(KIND_WRITE,  32'd3, END_MARK, '0));
    send_req(make_req(KIND_WALK,   32'd1,         '0, 32'd0));
    send_req(make_req(KIND_WALK,   32'hffff_ffff, '0, 32'd4095));
    send_req(make_req(KIND_WALK,   32'd1,         '0, 32'd4096));
    send_req(make_req(KIND_WALK,   32'd1,         '0, 32'd12287));
    send_req(make_req(KIND_WALK,   32'd1,         '0, 32'd12288));
    send_req(make_req(KIND_WALK,   TABLE_DEPTH,   '0, 32'd4096));
    send_req(make_req(KIND_APPEND, 32'd1, TABLE_DEPTH - 1, '0));
    send_req(make_req(KIND_WALK,   32'd1,         '0, 32'd12288));
    send_req(make_req(KIND_FREE,   32'd1,         '0, '0));
    send_req(make_req(KIND_READ,   32'd3,         '0, '0));
    // link just below the end mark, which points outside the table
    send_req(make_req(KIND_WRITE,  32'd4, END_MARK - 1, '0));
    send_req(make_req(KIND_WALK,   32'd4,         '0, 32'd8192));
    send_req(make_req(KIND_APPEND, 32'd4, 32'd9,  '0));
    send_req(make_req(KIND_FREE,   32'd4,         '0, '0));
    send_req(make_req(KIND_READ,   32'd4,         '0, '0));
  endtask

  task automatic test_unused_kinds();
    for (int k = int'(KIND_FREE) + 1; k < 8; k++)
      send_req(make_req(KIND_W'(k), $urandom_range(0, 15), $urandom, $urandom));
  endtask

  // Self-linked entry: walk and append exhaust the read budget; free runs
  // on through entry 0, which is still zero
  task automatic test_step_limit();
    send_req(make_req(KIND_WRITE,  32'd5, 32'd5, '0));
    send_req(make_req(KIND_WALK,   32'd5, '0, 32'hffff_ffff));
    send_req(make_req(KIND_APPEND, 32'd5, 32'd6, '0));
    send_req(make_req(KIND_FREE,   32'd5, '0, '0));
    send_req(make_req(KIND_READ,   32'd5, '0, '0));
  endtask

  task automatic test_cluster_sizes();
    logic [SPC_W-1:0] sizes [5];
    sizes[0] = 8'd1;
    sizes[1] = 8'd128;
    sizes[2] = 8'd0;
    sizes[3] = 8'd255;
    sizes[4] = 8'($urandom_range(2, 127));
    for (int i = 0; i < 5; i++) begin
      set_cluster_size(sizes[i]);
      steady_flow = (i == 1);
      // terminate chains that fall through to entry 0
      if (i == 0)
        send_req(make_req(KIND_WRITE, 32'd0, 32'hffff_ffff, '0));
      random_traffic(120);
    end
    steady_flow = 1'b0;
  endtask

  // Hold the result side off while transactions keep coming
  task automatic test_output_stall();
    wait_drain();
    hold_left = 400;
    random_traffic(24);
  endtask

  initial begin
    foreach (fat_tbl[i])
      fat_tbl[i] = '0;
    spc_reg = SPC_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_table_access();
    test_chain_ops();
    test_unused_kinds();
    test_step_limit();
    test_cluster_sizes();
    test_output_stall();

    wait_drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
